>>> rtl/core/tsq_pkg.sv
// tsq_pkg: shared types, widths and codes for the touch sample qualifier
// depends on nothing; imported by every module of the block
package tsq_pkg;

	// sample and datapath widths
	localparam int SAMPLE_BITS = 12;
	localparam int BYTE_W      = 8;
	localparam int RAW_W       = 2 * BYTE_W;
	localparam int QUO_W       = 2 * SAMPLE_BITS;
	localparam int PRESS_W     = 22;
	localparam int CMP_W       = (QUO_W > PRESS_W) ? QUO_W : PRESS_W;
	localparam int POS_W       = 14;
	localparam int CAL_W       = 12;
	localparam int LIMIT_W     = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [PRESS_W-1:0] PRESS_MAX = {PRESS_W{1'b1}};

	// calibration defaults
	localparam logic [CAL_W-1:0]   MIN_X_RST  = CAL_W'(60);
	localparam logic [CAL_W-1:0]   MAX_X_RST  = CAL_W'(3950);
	localparam logic [CAL_W-1:0]   MIN_Y_RST  = CAL_W'(160);
	localparam logic [CAL_W-1:0]   MAX_Y_RST  = CAL_W'(3850);
	localparam logic [LIMIT_W-1:0] LIMIT_RST  = LIMIT_W'(5000);

	typedef enum logic [1:0] {
		EV_DROP    = 2'd0,
		EV_TOUCH   = 2'd1,
		EV_RELEASE = 2'd2
	} event_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIRROR_X     = 3'd0,
		CFG_MIRROR_Y     = 3'd1,
		CFG_MIN_X        = 3'd2,
		CFG_MAX_X        = 3'd3,
		CFG_MIN_Y        = 3'd4,
		CFG_MAX_Y        = 3'd5,
		CFG_REJECT_LIMIT = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic               mirror_x;
		logic               mirror_y;
		logic [CAL_W-1:0]   min_x;
		logic [CAL_W-1:0]   max_x;
		logic [CAL_W-1:0]   min_y;
		logic [CAL_W-1:0]   max_y;
		logic [LIMIT_W-1:0] reject_limit;
	} cfg_t;

	// one frame in flight through the divider chain
	typedef struct packed {
		logic [SAMPLE_BITS-1:0] rem;
		logic [QUO_W-1:0]       acc;
		logic [SAMPLE_BITS-1:0] dvs;
		logic [SAMPLE_BITS-1:0] x;
		logic [SAMPLE_BITS-1:0] y;
		logic                   pen;
		logic                   zok;
	} div_beat_t;

	// join high byte and the top bits of the low byte into one sample
	function automatic logic [SAMPLE_BITS-1:0] unpack(input logic [BYTE_W-1:0] hi,
		input logic [BYTE_W-1:0] lo);
		logic [RAW_W-1:0] raw;
		raw = {hi, lo} >> (RAW_W - SAMPLE_BITS);
		return raw[SAMPLE_BITS-1:0];
	endfunction

endpackage

>>> rtl/core/tsq_front.sv
// tsq_front: sample unpack, z check and the x*(z2-z1) product, two stages
// depends on tsq_pkg
module tsq_front
	import tsq_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [BYTE_W-1:0] x_high,
	input  logic [BYTE_W-1:0] x_low,
	input  logic [BYTE_W-1:0] y_high,
	input  logic [BYTE_W-1:0] y_low,
	input  logic [BYTE_W-1:0] z1_high,
	input  logic [BYTE_W-1:0] z1_low,
	input  logic [BYTE_W-1:0] z2_high,
	input  logic [BYTE_W-1:0] z2_low,
	input  logic              pen_level,
	output logic              out_valid,
	input  logic              out_ready,
	output div_beat_t         out_beat
);

	logic [SAMPLE_BITS-1:0] x_w, y_w, z1_w, z2_w;
	logic [SAMPLE_BITS-1:0] x_s1, y_s1, z1_s1, diff_s1;
	logic                   pen_s1, zok_s1, vld_s1;
	logic                   vld_s2;
	div_beat_t              beat_s2;
	logic                   rdy_s1, rdy_s2;
	logic [QUO_W-1:0]       prod_w;

	// stage handshake, a stage loads when empty or draining
	assign rdy_s2   = !vld_s2 || out_ready;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	assign x_w  = unpack(x_high, x_low);
	assign y_w  = unpack(y_high, y_low);
	assign z1_w = unpack(z1_high, z1_low);
	assign z2_w = unpack(z2_high, z2_low);

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= in_valid;
		end
	end

	// stage 1 payload: samples, difference and z check
	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			x_s1    <= x_w;
			y_s1    <= y_w;
			z1_s1   <= z1_w;
			diff_s1 <= z2_w - z1_w;
			pen_s1  <= pen_level;
			zok_s1  <= (z1_w != '0) && (z2_w > z1_w);
		end
	end

	assign prod_w = QUO_W'(x_s1) * QUO_W'(diff_s1);

	// stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (rdy_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	// stage 2 payload: product becomes the dividend
	always_ff @(posedge clk) begin
		if (vld_s1 && rdy_s2) begin
			beat_s2.rem <= '0;
			beat_s2.acc <= prod_w;
			beat_s2.dvs <= z1_s1;
			beat_s2.x   <= x_s1;
			beat_s2.y   <= y_s1;
			beat_s2.pen <= pen_s1;
			beat_s2.zok <= zok_s1;
		end
	end

	assign out_valid = vld_s2;
	assign out_beat  = beat_s2;

endmodule

>>> rtl/core/tsq_cell.sv
// tsq_cell: one restoring-division cell, settles one quotient bit per beat
// depends on tsq_pkg
module tsq_cell
	import tsq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  div_beat_t in_beat,
	output logic      out_valid,
	input  logic      out_ready,
	output div_beat_t out_beat
);

	logic                 vld_q;
	div_beat_t            beat_q;
	logic [SAMPLE_BITS:0] trial_w, diff_w;
	logic                 ge_w;
	div_beat_t            next_w;

	assign in_ready = !vld_q || out_ready;

	// shift the next dividend bit into the remainder, subtract if it fits
	always_comb begin
		trial_w = {in_beat.rem, in_beat.acc[QUO_W-1]};
		diff_w  = trial_w - {1'b0, in_beat.dvs};
		ge_w    = trial_w >= {1'b0, in_beat.dvs};
		next_w      = in_beat;
		next_w.rem  = ge_w ? diff_w[SAMPLE_BITS-1:0] : trial_w[SAMPLE_BITS-1:0];
		next_w.acc  = {in_beat.acc[QUO_W-2:0], ge_w};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			beat_q <= next_w;
		end
	end

	assign out_valid = vld_q;
	assign out_beat  = beat_q;

endmodule

>>> rtl/core/tsq_qualify.sv
// tsq_qualify: pressure scaling, reject check, position mirroring, output register
// depends on tsq_pkg
module tsq_qualify
	import tsq_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  div_beat_t              in_beat,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [1:0]             event_kind,
	output logic signed [POS_W-1:0] pos_x,
	output logic signed [POS_W-1:0] pos_y,
	output logic [PRESS_W-1:0]     pressure
);

	logic [QUO_W-1:0]   q_sh_w;
	logic [CMP_W-1:0]   q_ext_w;
	logic [PRESS_W-1:0] press_w;
	logic [POS_W-1:0]   px_w, py_w;
	event_kind_t        kind_w;

	logic               vld_q;
	event_kind_t        kind_q;
	logic [POS_W-1:0]   px_q, py_q;
	logic [PRESS_W-1:0] press_q;

	assign in_ready = !vld_q || out_ready;

	// quotient divided by four, saturated, forced to all ones on bad z
	always_comb begin
		q_sh_w  = in_beat.acc >> 2;
		q_ext_w = CMP_W'(q_sh_w);
		if (!in_beat.zok || q_ext_w > CMP_W'(PRESS_MAX)) begin
			press_w = PRESS_MAX;
		end else begin
			press_w = q_ext_w[PRESS_W-1:0];
		end
	end

	// classify and place, positions wrap to the port width
	always_comb begin
		px_w   = '0;
		py_w   = '0;
		kind_w = EV_DROP;
		if (press_w > PRESS_W'(cfg.reject_limit)) begin
			kind_w = EV_DROP;
		end else if (!in_beat.pen) begin
			kind_w = EV_TOUCH;
			px_w = cfg.mirror_x ?
				POS_W'(cfg.max_x) - POS_W'(in_beat.x) + POS_W'(cfg.min_x) : POS_W'(in_beat.x);
			py_w = cfg.mirror_y ?
				POS_W'(cfg.max_y) - POS_W'(in_beat.y) + POS_W'(cfg.min_y) : POS_W'(in_beat.y);
		end else begin
			kind_w = EV_RELEASE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_q  <= kind_w;
			px_q    <= px_w;
			py_q    <= py_w;
			press_q <= press_w;
		end
	end

	assign out_valid  = vld_q;
	assign event_kind = kind_q;
	assign pos_x      = px_q;
	assign pos_y      = py_q;
	assign pressure   = press_q;

endmodule

>>> rtl/core/resistive_touch_sample_qualifier_top.sv
// Touch sample qualifier. Takes one converter frame per beat (X, Y, Z1, Z2 as
// byte pairs plus the pen pin level) and returns one event per frame: dropped,
// touch report with optionally mirrored position, or release, together with the
// touch resistance x*(z2-z1)/z1/4. Frames stream at one per clock while the
// output is not stalled; each frame passes the front stages, then the divider
// chain, which resolves one quotient bit per cell, then the output register.
// Any stage that sits empty lets the stage behind it move up, so a stalled
// output does not stop input until the chain is full. Calibration registers
// are written through cfg_we/cfg_index/cfg_data and should change only while
// no frame is in flight.
//
// top level: configuration registers, front stages, divider cells, qualify stage
// depends on tsq_pkg, tsq_front, tsq_cell, tsq_qualify
module resistive_touch_sample_qualifier_top
	import tsq_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [BYTE_W-1:0]       x_high,
	input  logic [BYTE_W-1:0]       x_low,
	input  logic [BYTE_W-1:0]       y_high,
	input  logic [BYTE_W-1:0]       y_low,
	input  logic [BYTE_W-1:0]       z1_high,
	input  logic [BYTE_W-1:0]       z1_low,
	input  logic [BYTE_W-1:0]       z2_high,
	input  logic [BYTE_W-1:0]       z2_low,
	input  logic                    pen_level,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [1:0]              event_kind,
	output logic signed [POS_W-1:0] pos_x,
	output logic signed [POS_W-1:0] pos_y,
	output logic [PRESS_W-1:0]      pressure
);

	cfg_t      cfg_q;
	div_beat_t beat_w [QUO_W+1];
	logic      vld_w  [QUO_W+1];
	logic      rdy_w  [QUO_W+1];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mirror_x     <= 1'b0;
			cfg_q.mirror_y     <= 1'b0;
			cfg_q.min_x        <= MIN_X_RST;
			cfg_q.max_x        <= MAX_X_RST;
			cfg_q.min_y        <= MIN_Y_RST;
			cfg_q.max_y        <= MAX_Y_RST;
			cfg_q.reject_limit <= LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MIRROR_X:     cfg_q.mirror_x     <= cfg_data[0];
				CFG_MIRROR_Y:     cfg_q.mirror_y     <= cfg_data[0];
				CFG_MIN_X:        cfg_q.min_x        <= cfg_data[CAL_W-1:0];
				CFG_MAX_X:        cfg_q.max_x        <= cfg_data[CAL_W-1:0];
				CFG_MIN_Y:        cfg_q.min_y        <= cfg_data[CAL_W-1:0];
				CFG_MAX_Y:        cfg_q.max_y        <= cfg_data[CAL_W-1:0];
				CFG_REJECT_LIMIT: cfg_q.reject_limit <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// unpack and multiply
	tsq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.x_high    (x_high),
		.x_low     (x_low),
		.y_high    (y_high),
		.y_low     (y_low),
		.z1_high   (z1_high),
		.z1_low    (z1_low),
		.z2_high   (z2_high),
		.z2_low    (z2_low),
		.pen_level (pen_level),
		.out_valid (vld_w[0]),
		.out_ready (rdy_w[0]),
		.out_beat  (beat_w[0])
	);

	// divider chain, one quotient bit per cell
	for (genvar i = 0; i < QUO_W; i++) begin : g_cell
		tsq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld_w[i]),
			.in_ready  (rdy_w[i]),
			.in_beat   (beat_w[i]),
			.out_valid (vld_w[i+1]),
			.out_ready (rdy_w[i+1]),
			.out_beat  (beat_w[i+1])
		);
	end

	// reject check, placement and output register
	tsq_qualify u_qualify (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (vld_w[QUO_W]),
		.in_ready   (rdy_w[QUO_W]),
		.in_beat    (beat_w[QUO_W]),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.event_kind (event_kind),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pressure   (pressure)
	);

endmodule

>>> rtl/core/tsq_checker.sv
// tsq_checker: port-level assertions for the touch sample qualifier, bound to the top
// depends on tsq_pkg and resistive_touch_sample_qualifier_top
module tsq_checker
	import tsq_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [1:0]              event_kind,
	input logic signed [POS_W-1:0] pos_x,
	input logic signed [POS_W-1:0] pos_y,
	input logic [PRESS_W-1:0]      pressure
);

	localparam int DEPTH = QUO_W + 3;
	localparam int CNT_W = $clog2(DEPTH + 1) + 1;

	logic [CNT_W-1:0] cnt_q;
	logic             in_beat_w, out_beat_w;

	assign in_beat_w  = in_valid && in_ready;
	assign out_beat_w = out_valid && out_ready;

	// frames accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_beat_w && !out_beat_w) begin
			cnt_q <= cnt_q + 1'b1;
		end else if (!in_beat_w && out_beat_w) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pressure) && $stable(event_kind))
		else $error("result changed while stalled");

	// no result without a frame behind it, and never more in flight than stages
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != '0 && cnt_q <= CNT_W'(DEPTH))
		else $error("result without matching frame");

	// only touch reports carry a position
	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind != EV_TOUCH |-> pos_x == '0 && pos_y == '0)
		else $error("position on non-touch event");

	// all-ones pressure is above any limit
	a_invalid_drops: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pressure == PRESS_MAX |-> event_kind == EV_DROP)
		else $error("invalid pressure not dropped");

endmodule

bind resistive_touch_sample_qualifier_top tsq_checker u_tsq_checker (.*);
